// ===== sv/ols_pkg.sv =====
package ols_pkg;

    // Position and data widths sized for the largest supported store
    localparam int PW = 9;
    localparam int WW = 64;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_FIND       = 3'd6,
        OP_READ       = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_HOLD  = 2'd0,
        MODE_OPEN  = 2'd1,
        MODE_CLOSE = 2'd2
    } t_mode;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic            go;
        t_mode           mode;
        logic [PW-1:0]   pos;
        logic [PW-1:0]   idx;
        logic [PW-1:0]   cnt;
        logic [WW-1:0]   word;
        logic            find;
        logic            read;
    } t_bcast;

    typedef struct packed {
        t_status      status;
        logic [31:0]  read_value;
        logic [4:0]   found_position;
        logic [31:0]  front_value;
        logic [31:0]  back_value;
        logic [4:0]   item_count;
    } t_rsp;

endpackage

// ===== sv/ols_if.sv =====
interface ols_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [4:0]  index;
    logic [31:0] value;

    modport source(output valid, opcode, index, value, input ready);
    modport sink(input valid, opcode, index, value, output ready);
endinterface

interface ols_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [4:0]  found_position;
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic [4:0]  item_count;

    modport source(output valid, status, read_value, found_position, front_value,
                   back_value, item_count, input ready);
    modport sink(input valid, status, read_value, found_position, front_value,
                 back_value, item_count, output ready);
endinterface

// ===== sv/ols_cell.sv =====
module ols_cell #(
    parameter int POS        = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  ols_pkg::t_bcast       i_bc,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_match,
    output logic                  o_hit
);
    import ols_pkg::*;

    localparam logic [PW-1:0] POS_V = PW'(POS);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_match;
    logic                  r_hit;
    logic [DATA_WIDTH-1:0] word_v;

    assign word_v = i_bc.word[DATA_WIDTH-1:0];

    // Shift toward the back to open a gap, toward the front to close one
    always_comb begin
        n_data = r_data;
        case (i_bc.mode)
            MODE_OPEN: begin
                if (POS_V > i_bc.pos) begin
                    n_data = i_left;
                end else if (POS_V == i_bc.pos) begin
                    n_data = word_v;
                end
            end
            MODE_CLOSE: begin
                if (POS_V >= i_bc.pos) begin
                    n_data = i_right;
                end
            end
            default: ;
        endcase
    end

    // Register the shifted data; latch compare and select flags per command
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_bc.go) begin
            r_match <= i_bc.find && (POS_V < i_bc.cnt) && (r_data == word_v);
            r_hit   <= i_bc.read && (POS_V == i_bc.idx);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;
    assign o_hit   = r_hit;

endmodule

// ===== sv/ols_result.sv =====
module ols_result #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic [DATA_WIDTH-1:0] i_data [DEPTH],
    input  logic [DEPTH-1:0]      i_match,
    input  logic [DEPTH-1:0]      i_hit,
    input  logic [ols_pkg::PW-1:0] i_cnt,
    input  logic                  i_find,
    input  ols_pkg::t_status      i_status,
    output ols_pkg::t_rsp         o_rsp
);
    import ols_pkg::*;

    logic [WW-1:0] read_acc;
    logic [WW-1:0] back_acc;
    logic [WW-1:0] front_w;
    logic [PW-1:0] back_pos;
    logic [PW-1:0] found;

    // Gather the read word, the front and back words and the first match over the row
    always_comb begin
        back_pos = i_cnt - PW'(1);
        read_acc = '0;
        back_acc = '0;
        found    = i_cnt;
        for (int k = 0; k < DEPTH; k++) begin
            if (i_hit[k]) begin
                read_acc = read_acc | WW'(i_data[k]);
            end
            if (PW'(k) == back_pos) begin
                back_acc = back_acc | WW'(i_data[k]);
            end
        end
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (i_match[k]) begin
                found = PW'(k);
            end
        end
        front_w = (i_cnt != '0) ? WW'(i_data[0]) : '0;
    end

    always_comb begin
        o_rsp.status         = i_status;
        o_rsp.read_value     = read_acc[31:0];
        o_rsp.found_position = i_find ? found[4:0] : 5'd0;
        o_rsp.front_value    = front_w[31:0];
        o_rsp.back_value     = (i_cnt != '0) ? back_acc[31:0] : 32'd0;
        o_rsp.item_count     = i_cnt[4:0];
    end

endmodule

// ===== sv/ordered_list_store.sv =====
// Channel | Dir | Word
// i_cmd   | in  | opcode, index, value
// o_rsp   | out | status, read_value, found_position, front_value, back_value, item_count
//
// The cell row shifts or compares on the edge that accepts a command, and the
// result is gathered from the row into the output register once the finish stage
// advances. With the output drained, a command is accepted every cycle.
// Reset (synchronous, active low) empties the store; cell contents are not cleared.
// A stalled output holds the finishing command, and no new command is taken.
module ordered_list_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ols_cmd_if.sink    i_cmd,
    ols_rsp_if.source  o_rsp
);
    import ols_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_busy;
    t_status               r_status;
    logic                  r_find;
    logic                  r_out_valid;
    t_rsp                  r_rsp;

    logic                  exec;
    logic                  fin_go;
    t_status               st_w;
    t_mode                 mode_w;
    logic [PW-1:0]         pos_w;
    logic                  find_w;
    logic                  read_w;
    logic [PW-1:0]         cnt_w;
    logic [PW-1:0]         idx_w;
    logic [PW-1:0]         depth_w;
    t_bcast                bc;
    t_rsp                  rsp_w;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      cell_match;
    logic [DEPTH-1:0]      cell_hit;

    assign cnt_w   = PW'(r_count);
    assign idx_w   = PW'(i_cmd.index);
    assign depth_w = PW'(DEPTH);

    // Handshake: take a word when the finish stage is free or draining
    assign fin_go      = r_busy && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = !r_busy || fin_go;
    assign exec        = i_cmd.valid && i_cmd.ready;

    // Decode the command and check it against the count
    always_comb begin
        st_w   = ST_OK;
        mode_w = MODE_HOLD;
        pos_w  = '0;
        find_w = 1'b0;
        read_w = 1'b0;
        unique case (t_op'(i_cmd.opcode))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (cnt_w >= depth_w) begin
                    st_w = ST_FULL;
                end else begin
                    mode_w = MODE_OPEN;
                    pos_w  = (t_op'(i_cmd.opcode) == OP_PUSH_FRONT) ? '0 : cnt_w;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (cnt_w == '0) begin
                    st_w = ST_EMPTY;
                end else begin
                    mode_w = MODE_CLOSE;
                    pos_w  = (t_op'(i_cmd.opcode) == OP_POP_FRONT) ? '0 : cnt_w - PW'(1);
                end
            end
            OP_INSERT: begin
                if (idx_w > cnt_w) begin
                    st_w = ST_RANGE;
                end else if (cnt_w >= depth_w) begin
                    st_w = ST_FULL;
                end else begin
                    mode_w = MODE_OPEN;
                    pos_w  = idx_w;
                end
            end
            OP_REMOVE: begin
                if (idx_w >= cnt_w) begin
                    st_w = ST_RANGE;
                end else begin
                    mode_w = MODE_CLOSE;
                    pos_w  = idx_w;
                end
            end
            OP_FIND: begin
                find_w = 1'b1;
            end
            OP_READ: begin
                if (idx_w >= cnt_w) begin
                    st_w = ST_RANGE;
                end else begin
                    read_w = 1'b1;
                end
            end
        endcase

        case (mode_w)
            MODE_OPEN:  n_count = r_count + CW'(1);
            MODE_CLOSE: n_count = r_count - CW'(1);
            default:    n_count = r_count;
        endcase
    end

    // Broadcast to the row only on an accepted word
    always_comb begin
        bc.go   = exec;
        bc.mode = exec ? mode_w : MODE_HOLD;
        bc.pos  = pos_w;
        bc.idx  = idx_w;
        bc.cnt  = cnt_w;
        bc.word = WW'(i_cmd.value);
        bc.find = find_w;
        bc.read = read_w;
    end

    // Row of cells, each passing its entry to its neighbors
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;
        if (k == 0) begin : g_first
            assign left_w = bc.word[DATA_WIDTH-1:0];
        end else begin : g_mid
            assign left_w = cell_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_inner
            assign right_w = cell_data[k+1];
        end
        ols_cell #(
            .POS        (k),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_bc    (bc),
            .i_left  (left_w),
            .i_right (right_w),
            .o_data  (cell_data[k]),
            .o_match (cell_match[k]),
            .o_hit   (cell_hit[k])
        );
    end

    ols_result #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_result (
        .i_data   (cell_data),
        .i_match  (cell_match),
        .i_hit    (cell_hit),
        .i_cnt    (cnt_w),
        .i_find   (r_find),
        .i_status (r_status),
        .o_rsp    (rsp_w)
    );

    // Advance count, finish stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_count <= n_count;
            end
            r_busy <= exec || (r_busy && !fin_go);
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (exec) begin
            r_status <= st_w;
            r_find   <= find_w;
        end
        if (fin_go) begin
            r_rsp <= rsp_w;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_rsp.status;
    assign o_rsp.read_value     = r_rsp.read_value;
    assign o_rsp.found_position = r_rsp.found_position;
    assign o_rsp.front_value    = r_rsp.front_value;
    assign o_rsp.back_value     = r_rsp.back_value;
    assign o_rsp.item_count     = r_rsp.item_count;

    // Count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_count) <= depth_w)
        else $error("count above capacity");

    // Count moves only on an accepted word
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec |=> $stable(r_count))
        else $error("count changed without a command");

    // A rejected command leaves the count alone
    a_err_nochange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && st_w != ST_OK) |=> $stable(r_count))
        else $error("failed command changed the count");

    // A word taken into an idle block reaches the output register next
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && !r_busy && !r_out_valid) |=> fin_go)
        else $error("finish stage stalled with output free");

endmodule
